// File: rtl/core/bms_pkg.sv
// Shared item codes, tone limits and preset melody tables for the buzzer melody sequencer.
package bms_pkg;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_PRESET = 3'd1;
  localparam logic [2:0] KIND_LOAD   = 3'd2;
  localparam logic [2:0] KIND_TONE   = 3'd3;
  localparam logic [2:0] KIND_STOP   = 3'd4;

  localparam logic [15:0] TONE_MIN = 16'd100;
  localparam logic [15:0] TONE_MAX = 16'd10000;

  localparam logic [3:0] PRESET_NUM = 4'd10;

  // {frequency, duration} of every preset note, melodies back to back
  function automatic logic [31:0] preset_note(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = {16'd262, 16'd100};
      6'd1:  v = {16'd330, 16'd100};
      6'd2:  v = {16'd392, 16'd100};
      6'd3:  v = {16'd523, 16'd200};
      6'd4:  v = {16'd150, 16'd80};
      6'd5:  v = {16'd200, 16'd60};
      6'd6:  v = {16'd150, 16'd80};
      6'd7:  v = {16'd200, 16'd60};
      6'd8:  v = {16'd0,   16'd50};
      6'd9:  v = {16'd150, 16'd80};
      6'd10: v = {16'd200, 16'd60};
      6'd11: v = {16'd100, 16'd150};
      6'd12: v = {16'd120, 16'd150};
      6'd13: v = {16'd100, 16'd150};
      6'd14: v = {16'd80,  16'd200};
      6'd15: v = {16'd880, 16'd50};
      6'd16: v = {16'd880, 16'd300};
      6'd17: v = {16'd523, 16'd100};
      6'd18: v = {16'd659, 16'd100};
      6'd19: v = {16'd784, 16'd150};
      6'd20: v = {16'd784, 16'd100};
      6'd21: v = {16'd659, 16'd100};
      6'd22: v = {16'd523, 16'd150};
      6'd23: v = {16'd800, 16'd200};
      6'd24: v = {16'd600, 16'd200};
      6'd25: v = {16'd800, 16'd200};
      6'd26: v = {16'd600, 16'd200};
      6'd27: v = {16'd523, 16'd150};
      6'd28: v = {16'd587, 16'd150};
      6'd29: v = {16'd659, 16'd150};
      6'd30: v = {16'd523, 16'd150};
      6'd31: v = {16'd659, 16'd150};
      6'd32: v = {16'd784, 16'd300};
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] preset_first(input logic [3:0] sid);
    logic [5:0] v;
    unique case (sid)
      4'd0: v = 6'd0;
      4'd1: v = 6'd4;
      4'd2: v = 6'd6;
      4'd3: v = 6'd11;
      4'd4: v = 6'd15;
      4'd5: v = 6'd16;
      4'd6: v = 6'd17;
      4'd7: v = 6'd20;
      4'd8: v = 6'd23;
      4'd9: v = 6'd27;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] preset_count(input logic [3:0] sid);
    logic [2:0] v;
    unique case (sid)
      4'd0: v = 3'd4;
      4'd1: v = 3'd2;
      4'd2: v = 3'd5;
      4'd3: v = 3'd4;
      4'd4: v = 3'd1;
      4'd5: v = 3'd1;
      4'd6: v = 3'd3;
      4'd7: v = 3'd3;
      4'd8: v = 3'd4;
      4'd9: v = 3'd6;
      default: v = 3'd1;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/bms_in_if.sv
// Request channel carrying one tick or command item into the sequencer.
interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  sound_id;
  logic [15:0] note_freq;
  logic [15:0] note_duration;
  logic        last_note;

  modport source (output valid, kind, sound_id, note_freq, note_duration, last_note,
                  input ready);
  modport sink   (input valid, kind, sound_id, note_freq, note_duration, last_note,
                  output ready);
endinterface

// File: rtl/core/bms_out_if.sv
// Result channel carrying the buzzer drive status after each request.
interface bms_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_freq;
  logic        playing;
  logic [3:0]  note_position;

  modport source (output valid, tone_on, tone_freq, playing, note_position,
                  input ready);
  modport sink   (input valid, tone_on, tone_freq, playing, note_position,
                  output ready);
endinterface

// File: rtl/core/buzzer_melody_sequencer_top.sv
// Buzzer melody sequencer: note buffer, preset copy engine and tick sequencer.
//
// Usage:
//   in_chan  (sink)   one request per 1 ms tick or per command: tick, preset
//                     play, load note, single tone, stop (kind codes in bms_pkg).
//   out_chan (source) one result per request: tone_on, tone_freq, playing and
//                     note_position as they stand after that request.
// Timing: a small sequencer works one request at a time over a single-port
//   note buffer with a registered read. A tick while playing reads the
//   current note from the buffer before checking its duration, and reads
//   and applies the next note when one starts; a load marked last reads
//   and applies the first note; preset play first copies one note per
//   cycle into the buffer, then starts the first note like a load.
//   in_chan.ready is high only while the sequencer is idle.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and the sequencer holds before writing a new result
//   until the old one has been taken.
// Reset (rst_n low, synchronous): playback stopped, counters and drive
//   cleared, no result pending. The note buffer is not cleared; only
//   entries written since are ever read.
module buzzer_melody_sequencer_top #(
  parameter int NOTE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bms_in_if.sink      in_chan,
  bms_out_if.source   out_chan
);
  import bms_pkg::*;

  localparam int IW = $clog2(NOTE_SLOTS);
  localparam int CW = $clog2(NOTE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_COPY, S_TICK_RD, S_TICK, S_BEGIN, S_APPLY, S_OUT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] total_r;
  logic [CW-1:0] cursor_r;
  logic [15:0]   elapsed_r;
  logic          busy_r;
  logic [CW-1:0] lc_r;
  logic          loading_r;
  logic          drive_on_r;
  logic [15:0]   drive_freq_r;
  logic [3:0]    sid_r;
  logic [2:0]    copy_i_r;
  logic [31:0]   rdata_r;

  logic          out_valid_r;
  logic          out_tone_on_r;
  logic [15:0]   out_tone_freq_r;
  logic          out_playing_r;
  logic [3:0]    out_pos_r;

  // note buffer: freq in [31:16], duration in [15:0]
  logic [31:0]   note_mem [NOTE_SLOTS];

  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          rd_en;

  logic          in_fire;
  logic [CW-1:0] lc_eff;
  logic          lc_room;
  logic [CW-1:0] lc_new;
  logic [15:0]   tone_f;
  logic [15:0]   el_inc;
  logic [CW-1:0] cursor_inc;
  logic [5:0]    rom_idx;
  logic [2:0]    copy_n;
  logic [CW+3:0] pos_ext;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && (state_r == S_IDLE);

  // load position: a fresh load sequence restarts at slot 0
  assign lc_eff  = loading_r ? lc_r : '0;
  assign lc_room = (lc_eff < CW'(NOTE_SLOTS));
  assign lc_new  = lc_eff + CW'(lc_room);

  assign tone_f = (in_chan.note_freq < TONE_MIN) ? TONE_MIN :
                  (in_chan.note_freq > TONE_MAX) ? TONE_MAX : in_chan.note_freq;

  assign el_inc     = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign cursor_inc = cursor_r + CW'(1);
  assign rom_idx    = preset_first(sid_r) + 6'(copy_i_r);
  assign copy_n     = preset_count(sid_r);
  assign pos_ext    = {4'd0, cursor_r};

  // buffer port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    rd_en  = (state_r == S_BEGIN) || (state_r == S_TICK_RD);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_chan.kind == KIND_LOAD && lc_room) begin
          mem_we = 1'b1;
          mem_wa = lc_eff[IW-1:0];
          mem_wd = {in_chan.note_freq, in_chan.note_duration};
        end else if (in_fire && in_chan.kind == KIND_TONE && in_chan.note_freq != 16'd0) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = {tone_f, in_chan.note_duration};
        end
      end
      S_COPY: begin
        mem_we = 1'b1;
        mem_wa = IW'(copy_i_r);
        mem_wd = preset_note(rom_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r <= note_mem[cursor_r[IW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      cursor_r     <= '0;
      elapsed_r    <= '0;
      busy_r       <= 1'b0;
      lc_r         <= '0;
      loading_r    <= 1'b0;
      drive_on_r   <= 1'b0;
      drive_freq_r <= '0;
      copy_i_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // a pending result can be taken in any state; S_OUT handles its own edge
      if (out_valid_r && out_chan.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_OUT;
            if (in_chan.kind == KIND_TICK || in_chan.kind == KIND_PRESET ||
                in_chan.kind == KIND_TONE || in_chan.kind == KIND_STOP) begin
              loading_r <= 1'b0;
            end
            unique case (in_chan.kind)
              KIND_TICK: begin
                if (busy_r) begin
                  state_r <= S_TICK_RD;
                end
              end
              KIND_PRESET: begin
                drive_on_r <= 1'b0;
                busy_r     <= 1'b0;
                total_r    <= '0;
                cursor_r   <= '0;
                if (in_chan.sound_id < PRESET_NUM) begin
                  sid_r    <= in_chan.sound_id;
                  copy_i_r <= '0;
                  state_r  <= S_COPY;
                end
              end
              KIND_LOAD: begin
                if (!loading_r) begin
                  drive_on_r <= 1'b0;
                  busy_r     <= 1'b0;
                  total_r    <= '0;
                  cursor_r   <= '0;
                  loading_r  <= 1'b1;
                end
                lc_r <= lc_new;
                if (in_chan.last_note) begin
                  loading_r <= 1'b0;
                  total_r   <= lc_new;
                  cursor_r  <= '0;
                  busy_r    <= 1'b1;
                  state_r   <= S_BEGIN;
                end
              end
              KIND_TONE: begin
                drive_on_r <= 1'b0;
                if (in_chan.note_freq != 16'd0) begin
                  drive_on_r   <= 1'b1;
                  drive_freq_r <= tone_f;
                  elapsed_r    <= '0;
                  total_r      <= CW'(1);
                  cursor_r     <= '0;
                  busy_r       <= 1'b1;
                end
              end
              KIND_STOP: begin
                drive_on_r <= 1'b0;
                busy_r     <= 1'b0;
                total_r    <= '0;
                cursor_r   <= '0;
              end
              default: ;
            endcase
          end
        end

        // one preset note per cycle into the buffer
        S_COPY: begin
          copy_i_r <= copy_i_r + 3'd1;
          if (copy_i_r == copy_n - 3'd1) begin
            total_r  <= CW'(copy_n);
            cursor_r <= '0;
            busy_r   <= 1'b1;
            state_r  <= S_BEGIN;
          end
        end

        S_TICK_RD: state_r <= S_TICK;

        S_TICK: begin
          elapsed_r <= el_inc;
          state_r   <= S_OUT;
          if (el_inc >= rdata_r[15:0]) begin
            if (cursor_inc >= total_r) begin
              drive_on_r <= 1'b0;
              busy_r     <= 1'b0;
              total_r    <= '0;
              cursor_r   <= '0;
            end else begin
              cursor_r <= cursor_inc;
              state_r  <= S_BEGIN;
            end
          end
        end

        S_BEGIN: state_r <= S_APPLY;

        // start the note just read; zero frequency is a pause
        S_APPLY: begin
          if (rdata_r[31:16] == 16'd0) begin
            drive_on_r <= 1'b0;
          end else begin
            drive_on_r   <= 1'b1;
            drive_freq_r <= rdata_r[31:16];
          end
          elapsed_r <= '0;
          state_r   <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r     <= 1'b1;
            out_tone_on_r   <= drive_on_r;
            out_tone_freq_r <= drive_freq_r;
            out_playing_r   <= busy_r;
            out_pos_r       <= pos_ext[3:0];
            state_r         <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.tone_on       = out_tone_on_r;
  assign out_chan.tone_freq     = out_tone_freq_r;
  assign out_chan.playing       = out_playing_r;
  assign out_chan.note_position = out_pos_r;

endmodule
